// File: hdl/hhp_pkg.sv
// Shared types and constants for the HTTP header parser.
// Used by every module of the parser; depends on nothing else.
package hhp_pkg;

   localparam int NUM_REGS = 8;
   localparam int REG_W    = 64;
   localparam int ADDR_W   = 6;
   localparam int IDX_LSB  = 3;

   typedef enum logic [2:0] {
      PH_START,
      PH_NAME,
      PH_SKIP,
      PH_VALUE,
      PH_IGNORE
   } phase_type;

   localparam logic [1:0] EV_BYTE = 2'd0;
   localparam logic [1:0] EV_DONE = 2'd1;
   localparam logic [1:0] EV_END  = 2'd2;
   localparam logic [1:0] EV_ERR  = 2'd3;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_COLON = 8'h3A;

   typedef logic [NUM_REGS-1:0][REG_W-1:0] name_regs_type;

   typedef struct packed {
      logic       hit;
      logic [1:0] event_res;
      logic [7:0] out_byte;
      logic [1:0] slot;
   } rslt_type;

   function automatic logic is_name_char(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
             (c >= 8'h61 && c <= 8'h7A) || (c == CH_DASH);
   endfunction

endpackage

// File: hdl/http_header_parser_unit.sv
// HTTP header parser top level: input beat register, parse state machine,
// result register and name configuration registers. Depends on hhp_pkg, hhp_csr, hhp_fsm and hhp_match.
// A byte sits in the input beat register, its result beat in the result register.
// One byte per cycle while no result beat is stalled; parse state updates once per byte.
// Bytes that give no result (CR, spaces, name characters, skipped lines) produce no beat.
// Reset (synchronous) returns to start of line, clears both beat valids and the names.
module http_header_parser_unit #(
   parameter int LINE_LIMIT = 512,
   parameter int NAME_SLOTS = 4,
   parameter int NAME_CHARS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [7:0]                  req_in_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [1:0]                  rsp_event_res,
   output logic [7:0]                  rsp_out_byte,
   output logic [1:0]                  rsp_slot,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [hhp_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [hhp_pkg::REG_W-1:0]   csr_pwdata,
   output logic [hhp_pkg::REG_W-1:0]   csr_prdata,
   output logic                        csr_pready
);
   import hhp_pkg::*;

   name_regs_type names;
   rslt_type      rslt;

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   logic [1:0] out_event_ff, out_event_in;
   logic [7:0] out_byte_ff, out_byte_in;
   logic [1:0] out_slot_ff, out_slot_in;
   logic       out_free;
   logic       step;

   hhp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .names       (names)
   );

   hhp_fsm #(
      .LINE_LIMIT (LINE_LIMIT),
      .NAME_SLOTS (NAME_SLOTS),
      .NAME_CHARS (NAME_CHARS)
   ) u_fsm (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .in_byte (in_byte_ff),
      .names   (names),
      .rslt    (rslt)
   );

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_event_in = out_event_ff;
      out_byte_in  = out_byte_ff;
      out_slot_in  = out_slot_ff;
      if (!req_stall) begin
         in_valid_in = req_valid;
         if (req_valid) begin
            in_byte_in = req_in_byte;
         end
      end
      if (out_free) begin
         out_valid_in = step && rslt.hit;
         if (step && rslt.hit) begin
            out_event_in = rslt.event_res;
            out_byte_in  = rslt.out_byte;
            out_slot_in  = rslt.slot;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_byte_ff   <= in_byte_in;
      out_event_ff <= out_event_in;
      out_byte_ff  <= out_byte_in;
      out_slot_ff  <= out_slot_in;
   end

   assign rsp_valid     = out_valid_ff;
   assign rsp_event_res = out_event_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_slot      = out_slot_ff;

endmodule

// File: hdl/hhp_csr.sv
// Configuration registers holding the header names, with APB-style access.
// Depends on hhp_pkg.
module hhp_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [hhp_pkg::ADDR_W-1:0]  csr_paddr,
   input  logic [hhp_pkg::REG_W-1:0]   csr_pwdata,
   output logic [hhp_pkg::REG_W-1:0]   csr_prdata,
   output logic                        csr_pready,
   output hhp_pkg::name_regs_type      names
);
   import hhp_pkg::*;

   name_regs_type                        regs_ff;
   name_regs_type                        regs_in;
   logic [ADDR_W-IDX_LSB-1:0]            idx;
   logic                                 wr_en;

   assign idx   = csr_paddr[ADDR_W-1:IDX_LSB];
   assign wr_en = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      regs_in = regs_ff;
      if (wr_en) begin
         regs_in[idx] = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= '0;
      end else begin
         regs_ff <= regs_in;
      end
   end

   assign csr_prdata = regs_ff[idx];
   assign csr_pready = 1'b1;
   assign names      = regs_ff;

endmodule

// File: hdl/hhp_match.sv
// Compares one character position of every name slot against a byte.
// Depends on hhp_pkg.
module hhp_match #(
   parameter int NAME_SLOTS = 4,
   parameter int NAME_CHARS = 16,
   parameter int CNT_W      = 9
) (
   input  hhp_pkg::name_regs_type names,
   input  logic [NAME_SLOTS-1:0]  bits,
   input  logic [CNT_W-1:0]       pos,
   input  logic [7:0]             chr,
   output logic [NAME_SLOTS-1:0]  match
);
   import hhp_pkg::*;

   logic in_range;

   assign in_range = {1'b0, pos} < (CNT_W+1)'(NAME_CHARS);

   for (genvar s = 0; s < NAME_SLOTS; s++) begin : g_slot
      logic [REG_W-1:0] word;
      logic [7:0]       ref_chr;

      assign word     = names[{2'(s), pos[3]}];
      assign ref_chr  = in_range ? word[pos[2:0]*8 +: 8] : CH_NUL;
      assign match[s] = bits[s] && (ref_chr == chr);
   end

endmodule

// File: hdl/hhp_fsm.sv
// Parse state machine: phase, counter, candidate slots and result decode.
// Depends on hhp_pkg and hhp_match.
module hhp_fsm #(
   parameter int LINE_LIMIT = 512,
   parameter int NAME_SLOTS = 4,
   parameter int NAME_CHARS = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   step,
   input  logic [7:0]             in_byte,
   input  hhp_pkg::name_regs_type names,
   output hhp_pkg::rslt_type      rslt
);
   import hhp_pkg::*;

   localparam int CNT_W = $clog2(LINE_LIMIT);

   phase_type             phase_ff, phase_in;
   logic [CNT_W-1:0]      count_ff, count_in;
   logic [NAME_SLOTS-1:0] bits_ff, bits_in;
   logic [1:0]            slot_ff, slot_in;

   logic [NAME_SLOTS-1:0] m_bits;
   logic [CNT_W-1:0]      m_pos;
   logic [7:0]            m_chr;
   logic [NAME_SLOTS-1:0] match;
   logic                  hit_any;
   logic [1:0]            hit_slot;
   logic                  at_limit;
   logic                  is_name;

   assign m_bits = (phase_ff == PH_START) ? '1 : bits_ff;
   assign m_pos  = (phase_ff == PH_START) ? '0 : count_ff;
   assign m_chr  = (phase_ff == PH_NAME && in_byte == CH_COLON) ? CH_NUL : in_byte;

   hhp_match #(
      .NAME_SLOTS (NAME_SLOTS),
      .NAME_CHARS (NAME_CHARS),
      .CNT_W      (CNT_W)
   ) u_match (
      .names (names),
      .bits  (m_bits),
      .pos   (m_pos),
      .chr   (m_chr),
      .match (match)
   );

   always_comb begin
      hit_any  = |match;
      hit_slot = 2'd0;
      for (int s = NAME_SLOTS - 1; s >= 0; s--) begin
         if (match[s]) begin
            hit_slot = 2'(s);
         end
      end
   end

   assign at_limit = count_ff == CNT_W'(LINE_LIMIT - 1);
   assign is_name  = is_name_char(in_byte);

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      bits_in  = bits_ff;
      slot_in  = slot_ff;
      rslt     = '0;
      if (step) begin
         case (phase_ff)
            PH_START: begin
               if (in_byte == CH_CR) begin
                  phase_in = PH_START;
               end else if (in_byte == CH_LF) begin
                  count_in       = '0;
                  bits_in        = '1;
                  rslt.hit       = 1'b1;
                  rslt.event_res = EV_END;
               end else if (!is_name) begin
                  count_in       = '0;
                  bits_in        = '1;
                  rslt.hit       = 1'b1;
                  rslt.event_res = EV_ERR;
               end else begin
                  bits_in  = match;
                  count_in = CNT_W'(1);
                  phase_in = PH_NAME;
               end
            end
            PH_NAME: begin
               if (at_limit || (in_byte != CH_COLON && !is_name)) begin
                  phase_in       = PH_START;
                  count_in       = '0;
                  bits_in        = '1;
                  rslt.hit       = 1'b1;
                  rslt.event_res = EV_ERR;
               end else if (in_byte == CH_COLON) begin
                  count_in = '0;
                  if (hit_any) begin
                     slot_in  = hit_slot;
                     phase_in = PH_SKIP;
                  end else begin
                     phase_in = PH_IGNORE;
                  end
               end else begin
                  bits_in  = match;
                  count_in = count_ff + CNT_W'(1);
               end
            end
            PH_SKIP, PH_VALUE: begin
               if (at_limit) begin
                  phase_in       = PH_START;
                  count_in       = '0;
                  bits_in        = '1;
                  rslt.hit       = 1'b1;
                  rslt.event_res = EV_ERR;
               end else if (in_byte == CH_LF) begin
                  phase_in       = PH_START;
                  count_in       = '0;
                  bits_in        = '1;
                  rslt.hit       = 1'b1;
                  rslt.event_res = EV_DONE;
                  rslt.slot      = slot_ff;
               end else if (in_byte == CH_CR ||
                            (in_byte == CH_SPACE && phase_ff == PH_SKIP)) begin
                  phase_in = phase_ff;
               end else begin
                  phase_in       = PH_VALUE;
                  count_in       = count_ff + CNT_W'(1);
                  rslt.hit       = 1'b1;
                  rslt.event_res = EV_BYTE;
                  rslt.out_byte  = in_byte;
                  rslt.slot      = slot_ff;
               end
            end
            PH_IGNORE: begin
               if (in_byte == CH_LF) begin
                  phase_in = PH_START;
                  count_in = '0;
                  bits_in  = '1;
               end
            end
            default: begin
               phase_in = PH_START;
               count_in = '0;
               bits_in  = '1;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         count_ff <= '0;
         bits_ff  <= '1;
         slot_ff  <= 2'd0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         bits_ff  <= bits_in;
         slot_ff  <= slot_in;
      end
   end

endmodule

// File: hdl/hhp_checker.sv
// Port-level checks on the result channel of the HTTP header parser, bound to the top level.
// Depends on hhp_pkg and http_header_parser_unit.
module hhp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [1:0] rsp_event_res,
   input logic [7:0] rsp_out_byte,
   input logic [1:0] rsp_slot
);
   import hhp_pkg::*;

   a_reset_clears : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat valid right after reset");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_event_res) &&
      $stable(rsp_out_byte) && $stable(rsp_slot))
      else $error("stalled result beat changed");

   a_byte_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res != EV_BYTE |-> rsp_out_byte == CH_NUL)
      else $error("non-byte event carries a byte");

   a_slot_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_END || rsp_event_res == EV_ERR) |->
      rsp_slot == 2'd0)
      else $error("end or error event carries a slot");

   a_no_line_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_res == EV_BYTE |->
      rsp_out_byte != CH_CR && rsp_out_byte != CH_LF)
      else $error("value byte is a line terminator");

endmodule

bind http_header_parser_unit hhp_checker u_checker (.*);
